### hw/rtl/esckd_pkg.sv
// Shared types, constants and the fixed key table for the escape key
// sequence decoder. No dependencies.
package esckd_pkg;

  localparam int SEQ_BYTES     = 6;
  localparam int TABLE_ENTRIES = 13;
  localparam int CFG_REGS      = 5;
  localparam int FIXED_ENTRIES = 8;
  localparam int LEN_W         = 3;
  localparam int IDX_W         = 3;
  localparam int CODE_W        = 9;
  localparam int SEQ_W         = 51;
  localparam int LEN_LSB       = 48;
  localparam int DATA_W        = 64;
  localparam int ADDR_W        = 6;

  typedef logic [SEQ_W-1:0]  seq_word_t;
  typedef logic [CODE_W-1:0] key_code_t;

  localparam logic [7:0] ESC_BYTE = 8'h1b;

  localparam key_code_t KEY_LEFT   = 9'h101;
  localparam key_code_t KEY_RIGHT  = 9'h102;
  localparam key_code_t KEY_UP     = 9'h103;
  localparam key_code_t KEY_DOWN   = 9'h104;
  localparam key_code_t KEY_DELETE = 9'h108;

  // Register indexes, in address order
  localparam logic [IDX_W-1:0] REG_LEFT   = 3'd0;
  localparam logic [IDX_W-1:0] REG_RIGHT  = 3'd1;
  localparam logic [IDX_W-1:0] REG_UP     = 3'd2;
  localparam logic [IDX_W-1:0] REG_DOWN   = 3'd3;
  localparam logic [IDX_W-1:0] REG_DELETE = 3'd4;

  function automatic seq_word_t fixed3(logic [7:0] b1, logic [7:0] b2);
    fixed3 = {3'd3, 24'h0, b2, b1, ESC_BYTE};
  endfunction

  localparam seq_word_t FIXED_SEQ [FIXED_ENTRIES] = '{
    fixed3(8'h5b, 8'h44), fixed3(8'h5b, 8'h43), fixed3(8'h5b, 8'h41), fixed3(8'h5b, 8'h42),
    fixed3(8'h4f, 8'h44), fixed3(8'h4f, 8'h43), fixed3(8'h4f, 8'h41), fixed3(8'h4f, 8'h42)
  };

  localparam key_code_t ENTRY_CODE [TABLE_ENTRIES] = '{
    KEY_LEFT, KEY_RIGHT, KEY_UP, KEY_DOWN,
    KEY_LEFT, KEY_RIGHT, KEY_UP, KEY_DOWN,
    KEY_LEFT, KEY_RIGHT, KEY_UP, KEY_DOWN,
    KEY_DELETE
  };

  // Outcome of one byte, from the matcher to the control path
  typedef struct packed {
    logic             emit;
    key_code_t        code;
    logic [LEN_W-1:0] next_len;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
  } esckd_res_t;

endpackage

### hw/rtl/escape_key_sequence_decoder.sv
// Escape key sequence decoder, top level.
// One byte per cycle unless a key code meets a stalled output; one input register,
// one matcher pass and one result register, which drives out_tvalid.
// A byte that yields no key code leaves the input register without waiting for the output.
// Reset (synchronous, rst_n low): no sequence in progress, both stages empty, registers zero.
module escape_key_sequence_decoder
  import esckd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,    // [7:0] in_byte
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,   // [8:0] key_code, [15:9] zero
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  seq_word_t        seq_cfg [CFG_REGS];
  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;
  logic [LEN_W-1:0] len_r;
  logic [7:0]       bytes_r [SEQ_BYTES];
  logic             out_valid_r;
  key_code_t        out_code_r;
  esckd_res_t       res;
  logic             s1_adv;

  esckd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .seq_cfg     (seq_cfg)
  );

  esckd_match u_match (
    .len      (len_r),
    .bytes_in (bytes_r),
    .in_byte  (s1_byte_r),
    .seq_cfg  (seq_cfg),
    .res      (res)
  );

  // advance unless a key code would land on a stalled output
  assign s1_adv    = s1_valid_r && (!res.emit || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) s1_byte_r <= in_tdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (s1_adv) begin
      len_r <= res.next_len;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res.wr_en) bytes_r[res.wr_idx] <= s1_byte_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && res.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res.emit) out_code_r <= res.code;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_code_r};

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(SEQ_BYTES))
    else $error("collected length beyond buffer");

  a_esc_head: assert property (@(posedge clk) disable iff (!rst_n)
    len_r != '0 |-> bytes_r[0] == ESC_BYTE)
    else $error("sequence in progress without ESC at head");

  a_plain_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && len_r == '0 && s1_byte_r != ESC_BYTE)
      |=> out_valid_r && out_code_r == CODE_W'($past(s1_byte_r)))
    else $error("plain byte not passed through");

  a_key_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_code_r[CODE_W-1]) |->
      (out_code_r == KEY_LEFT || out_code_r == KEY_RIGHT || out_code_r == KEY_UP ||
       out_code_r == KEY_DOWN || out_code_r == KEY_DELETE))
    else $error("unknown key code on output");

endmodule

### hw/rtl/esckd_cfg.sv
// APB-style register file holding the five programmable key sequences.
// Depends on esckd_pkg.
module esckd_cfg
  import esckd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready,
  output seq_word_t         seq_cfg [CFG_REGS]
);

  seq_word_t        seq_r [CFG_REGS];
  logic [IDX_W-1:0] reg_idx;
  logic             wr_en;
  logic             idx_ok;

  assign reg_idx    = cfg_paddr[ADDR_W-1:3];
  assign idx_ok     = reg_idx < IDX_W'(CFG_REGS);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && idx_ok;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CFG_REGS; i++) seq_r[i] <= '0;
    end else if (wr_en) begin
      seq_r[reg_idx] <= cfg_pwdata[SEQ_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (idx_ok) cfg_prdata = DATA_W'(seq_r[reg_idx]);
  end

  assign seq_cfg = seq_r;

endmodule

### hw/rtl/esckd_match.sv
// Combinational matcher: appends one byte to the collected sequence and
// compares it against all table entries in parallel. Depends on esckd_pkg.
module esckd_match
  import esckd_pkg::*;
(
  input  logic [LEN_W-1:0] len,
  input  logic [7:0]       bytes_in [SEQ_BYTES],
  input  logic [7:0]       in_byte,
  input  seq_word_t        seq_cfg  [CFG_REGS],
  output esckd_res_t       res
);

  logic [7:0]         buf_b [SEQ_BYTES];
  seq_word_t          word  [TABLE_ENTRIES];
  logic [LEN_W-1:0]   elen  [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] hit;
  logic [TABLE_ENTRIES-1:0] exact;
  logic [LEN_W-1:0]   n;
  logic               same;
  key_code_t          code;

  always_comb begin
    n = len + LEN_W'(1);
    for (int i = 0; i < SEQ_BYTES; i++) begin
      buf_b[i] = (IDX_W'(i) == len) ? in_byte : bytes_in[i];
    end

    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      if (k < 4) word[k] = seq_cfg[k];
      else if (k < 4 + FIXED_ENTRIES) word[k] = FIXED_SEQ[k-4];
      else if (k == 4 + FIXED_ENTRIES) word[k] = seq_cfg[REG_DELETE];
      else word[k] = '0;
    end

    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      elen[k] = word[k][LEN_LSB +: LEN_W];
      if (elen[k] > LEN_W'(SEQ_BYTES)) elen[k] = LEN_W'(SEQ_BYTES);
      same = 1'b1;
      for (int i = 0; i < SEQ_BYTES; i++) begin
        if (IDX_W'(i) < n && word[k][8*i +: 8] != buf_b[i]) same = 1'b0;
      end
      hit[k]   = (elen[k] != '0) && (elen[k] >= n) && same;
      exact[k] = hit[k] && (elen[k] == n);
    end

    // Walk down so the lowest matching entry wins
    code = '0;
    for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
      if (exact[k]) code = ENTRY_CODE[k];
    end

    res        = '0;
    res.wr_idx = len;
    if (len == '0) begin
      if (in_byte != ESC_BYTE) begin
        res.emit = 1'b1;
        res.code = CODE_W'(in_byte);
      end else begin
        res.wr_en    = 1'b1;
        res.next_len = LEN_W'(1);
      end
    end else if (len >= LEN_W'(SEQ_BYTES)) begin
      // full buffer: drop it
      res.next_len = '0;
    end else begin
      res.wr_en = 1'b1;
      if (|exact) begin
        res.emit     = 1'b1;
        res.code     = code;
        res.next_len = '0;
      end else if (|hit) begin
        res.next_len = n;
      end else begin
        res.next_len = '0;
      end
    end
  end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for escape_key_sequence_decoder: bytes in, key codes out.
// Holds its own model of the sequence matcher; needs esckd_pkg and the RTL only.
module tb;
  import esckd_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int DRAIN_WAIT  = 4;
  localparam int TAIL_WAIT   = 10;
  localparam int PHASE_BYTES = 200;
  localparam int PHASES      = 8;
  localparam int DELETE_SLOT = 12;

  // Decoder model plus the queue of key codes still to arrive
  class key_tracker;
    seq_word_t   key_reg [CFG_REGS];
    int unsigned seq_len;
    logic [7:0]  seq_buf [SEQ_BYTES];
    key_code_t   expected_keys [$];
    int          errors;

    function void clear();
      foreach (key_reg[i]) key_reg[i] = '0;
      foreach (seq_buf[i]) seq_buf[i] = '0;
      seq_len = 0;
      errors  = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, seq_word_t val);
      key_reg[idx] = val;
    endfunction

    function seq_word_t std_seq(int j);
      logic [7:0] b1;
      logic [7:0] b2;
      b1 = (j < 4) ? 8'h5b : 8'h4f;
      case (j % 4)
        0:       b2 = 8'h44;
        1:       b2 = 8'h43;
        2:       b2 = 8'h41;
        default: b2 = 8'h42;
      endcase
      return {3'd3, 24'h0, b2, b1, ESC_BYTE};
    endfunction

    function seq_word_t slot_word(int slot);
      if (slot < 4) return key_reg[slot];
      if (slot < DELETE_SLOT) return std_seq(slot - 4);
      if (slot == DELETE_SLOT) return key_reg[REG_DELETE];
      return '0;
    endfunction

    function int slot_len(seq_word_t w);
      int len;
      len = int'(w[SEQ_W-1:LEN_LSB]);
      return (len > SEQ_BYTES) ? SEQ_BYTES : len;
    endfunction

    function key_code_t slot_code(int slot);
      if (slot == DELETE_SLOT) return KEY_DELETE;
      return key_code_t'(KEY_LEFT + (slot % 4));
    endfunction

    function int pending();
      return expected_keys.size();
    endfunction

    function void decode_byte(logic [7:0] b);
      seq_word_t w;
      int        len;
      int        n;
      bit        same;
      bit        prefix;
      prefix = 0;
      if (seq_len == 0) begin
        if (b != ESC_BYTE) begin
          expected_keys.push_back(key_code_t'(b));
        end else begin
          seq_buf[0] = b;
          seq_len    = 1;
        end
        return;
      end
      // guard: a full buffer is dropped
      if (seq_len >= SEQ_BYTES) begin
        seq_len = 0;
        return;
      end
      seq_buf[seq_len] = b;
      seq_len++;
      n = seq_len;
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
        w   = slot_word(k);
        len = slot_len(w);
        if (len == 0 || len < n) continue;
        same = 1;
        for (int i = 0; i < n; i++)
          if (w[8*i +: 8] != seq_buf[i]) same = 0;
        if (!same) continue;
        if (len == n) begin
          seq_len = 0;
          expected_keys.push_back(slot_code(k));
          return;
        end
        prefix = 1;
      end
      if (!prefix) seq_len = 0;
    endfunction

    function void check_key(logic [15:0] data);
      key_code_t want;
      if (expected_keys.size() == 0) begin
        $display("%0t: unexpected key code, expected none, actual 0x%04h", $time, data);
        errors++;
        return;
      end
      want = expected_keys.pop_front();
      if (data[CODE_W-1:0] !== want || data[15:CODE_W] !== '0) begin
        $display("%0t: key_code mismatch, expected 0x%03h, actual 0x%04h", $time, want, data);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [7:0]        in_tdata;    // [7:0] in_byte
  logic              out_tvalid;
  logic              out_tready;
  logic [15:0]       out_tdata;   // [8:0] key_code, [15:9] zero
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [DATA_W-1:0] cfg_pwdata;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  key_tracker trk = new;
  bit         gaps_on;
  bit         stalls_on;
  int         phase_bytes;
  int         idle_cycles;

  escape_key_sequence_decoder u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Monitor both channels; results can never share an edge with their own byte
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) trk.check_key(out_tdata);
      if (in_tvalid && in_tready) trk.decode_byte(in_tdata);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: per transfer, hold tready low for a random number of cycles
  initial begin
    int n;
    out_tready = 1'b0;
    forever begin
      n = stalls_on ? $urandom_range(0, 7) : 0;
      if (n > 0) begin
        out_tready = 1'b0;
        repeat (n) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!(out_tvalid && rst_n));
      @(negedge clk);
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 4))
      0:       return 8'($urandom_range(0, 255));
      1:       return 8'h5b;
      2:       return 8'h4f;
      3:       return ESC_BYTE;
      default: return 8'($urandom_range(8'h30, 8'h44));
    endcase
  endfunction

  function automatic seq_word_t rand_key_word();
    seq_word_t w;
    w = '0;
    case ($urandom_range(0, 7))
      0: w = '0;
      1: w = '1;
      2: w = seq_word_t'({$urandom, $urandom});
      3: w = trk.std_seq($urandom_range(0, 7));
      default: begin
        for (int i = 0; i < SEQ_BYTES; i++) w[8*i +: 8] = pick_byte();
        w[7:0] = ESC_BYTE;
        w[SEQ_W-1:LEN_LSB] = 3'($urandom_range(2, 7));
      end
    endcase
    return w;
  endfunction

  // Ends at the falling edge after the transfer, with tvalid still high
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = gaps_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    phase_bytes++;
  endtask

  task automatic send_bytes(input logic [7:0] bytes [$]);
    foreach (bytes[i]) send_byte(bytes[i]);
  endtask

  // Send an entry, whole or cut short and a stray byte (ESC, any byte if short)
  task automatic send_slot(input int slot, input bit broken);
    seq_word_t w;
    int        len;
    int        cut;
    w   = trk.slot_word(slot);
    len = trk.slot_len(w);
    if (len < 2) begin
      send_byte(ESC_BYTE);
      send_byte(pick_byte());
      return;
    end
    cut = broken ? $urandom_range(1, len - 1) : len;
    for (int i = 0; i < cut; i++) send_byte(w[8*i +: 8]);
    if (broken) send_byte(pick_byte());
  endtask

  task automatic write_key_reg(input logic [IDX_W-1:0] idx, input seq_word_t val);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = ADDR_W'(8 * idx);
    cfg_pwdata  = DATA_W'(val);
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    trk.set_reg(idx, val);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic program_keys(input seq_word_t l, r, u, d, del);
    write_key_reg(REG_LEFT, l);
    write_key_reg(REG_RIGHT, r);
    write_key_reg(REG_UP, u);
    write_key_reg(REG_DOWN, d);
    write_key_reg(REG_DELETE, del);
  endtask

  // Drop tvalid, wait for every key code, then let the pipeline empty
  task automatic drain();
    in_tvalid = 1'b0;
    while (trk.pending() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  initial begin
    seq_word_t regs [CFG_REGS];
    int        r;
    trk.clear();
    gaps_on     = 1'b1;
    stalls_on   = 1'b1;
    phase_bytes = 0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset table: plain bytes, standard arrows, a dead sequence, ESC ESC
    send_bytes('{8'h00, 8'hff});
    send_bytes('{ESC_BYTE, 8'h5b, 8'h41});
    send_bytes('{ESC_BYTE, 8'h4f, 8'h42});
    send_bytes('{ESC_BYTE, 8'h5b, 8'h58});
    send_bytes('{ESC_BYTE, ESC_BYTE});
    drain();

    // Over-long length, priority over a standard entry, zero bytes, delete
    program_keys({3'd7, 48'h44_35_3b_31_5b_1b}, trk.std_seq(2),
                 {3'd3, 24'h0, 8'h00, 8'h00, ESC_BYTE}, '0,
                 {3'd4, 16'h0, 8'h7e, 8'h33, 8'h5b, ESC_BYTE});
    send_bytes('{ESC_BYTE, 8'h5b, 8'h31, 8'h3b, 8'h35, 8'h44});
    send_bytes('{ESC_BYTE, 8'h5b, 8'h41});
    send_bytes('{ESC_BYTE, 8'h00, 8'h00});
    send_bytes('{ESC_BYTE, 8'h5b, 8'h33, 8'h7e});

    for (int p = 0; p < PHASES; p++) begin
      drain();
      foreach (regs[i]) begin
        if (p == 0) regs[i] = '0;
        else if (p == 1) regs[i] = '1;
        else regs[i] = rand_key_word();
      end
      program_keys(regs[REG_LEFT], regs[REG_RIGHT], regs[REG_UP], regs[REG_DOWN],
                   regs[REG_DELETE]);
      gaps_on   = (p == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
      stalls_on = (p == 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        r = $urandom_range(0, 9);
        if (r < 7) send_slot($urandom_range(0, TABLE_ENTRIES - 1), 1'b0);
        else if (r == 7) send_slot($urandom_range(0, TABLE_ENTRIES - 1), 1'b1);
        else if (r == 8) send_byte(8'($urandom_range(0, 255)));
        else send_bytes('{ESC_BYTE, 8'($urandom_range(0, 255))});
      end
    end

    in_tvalid = 1'b0;
    while (trk.pending() > 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (trk.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/esckd_pkg.sv
hw/rtl/esckd_cfg.sv
hw/rtl/esckd_match.sv
hw/rtl/escape_key_sequence_decoder.sv
bench/tb.sv
